// File: hdl/line_bitset_intersection_filter_top_defines.svh
// Assertion helpers for the filter RTL.
`ifndef LINE_BITSET_INTERSECTION_FILTER_TOP_DEFINES_SVH
`define LINE_BITSET_INTERSECTION_FILTER_TOP_DEFINES_SVH

// Same-cycle implication check.
`define LBIF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbif check failed");

// Next-cycle implication check.
`define LBIF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbif check failed");

`endif

// File: hdl/lbif_pkg.sv
package lbif_pkg;

    localparam int DEF_MAX_A_LINES = 4096;
    localparam int DEF_MAX_B_LINES = 4096;
    localparam int DEF_ORDER       = 10;

    localparam int ROW_WORDS  = 64;
    localparam int POINTS     = 100;
    localparam int HIGH_BITS  = 36;

    // Input command codes.
    localparam logic [1:0] CMD_TABLE = 2'd0;
    localparam logic [1:0] CMD_MASK  = 2'd1;
    localparam logic [1:0] CMD_SLOT  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_LINES = 1'b0;
    localparam logic REG_COVER = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_ENOUGH  = 2'd0;
    localparam logic [1:0] ST_FEW     = 2'd1;
    localparam logic [1:0] ST_EMPTIED = 2'd2;
    localparam logic [1:0] ST_NOSLOT  = 2'd3;

    typedef enum logic [1:0] {
        K_TABLE,
        K_MASK,
        K_SLOT
    } kind_t;

    // One classified item passed from the front to the back.
    typedef struct packed {
        kind_t        kind;
        logic [17:0]  address;
        logic [99:0]  data;
        logic [11:0]  line_index;
        logic         use_slot;
        logic         last;
    } entry_t;

    function automatic logic [6:0] pop_count(input logic [63:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++)
        begin
            n = n + 7'(v[i]);
        end
        return n;
    endfunction

    // Index of the lowest set bit.
    function automatic logic [5:0] low_index(input logic [63:0] v);
        logic [63:0] low;
        logic [5:0]  idx;
        low = v & (~v + 64'd1);
        idx = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (low[i])
            begin
                idx = idx | 6'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: hdl/lbif_ram.sv
module lbif_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/lbif_front.sv
module lbif_front
    import lbif_pkg::*;
#(
    parameter int MAX_A_LINES = DEF_MAX_A_LINES,
    parameter int MAX_B_LINES = DEF_MAX_B_LINES,
    parameter int ORDER       = DEF_ORDER
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   cmd,
    input  logic [17:0]  address,
    input  logic [63:0]  data_low,
    input  logic [35:0]  data_high,
    input  logic [11:0]  line_index,
    input  logic         index_valid,
    input  logic         last_index,
    output logic         push,
    output entry_t       push_entry,
    input  logic         q_full
);

    localparam int SCW = $clog2(ORDER + 1);
    localparam logic [SCW-1:0] ORDER_C = SCW'(ORDER);

    logic [SCW-1:0] slot_cnt_reg, slot_cnt_next;
    logic           accept;
    logic           in_range;
    logic           slot_use;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Classify the word and check its address range.
    always_comb
    begin
        slot_use = index_valid && (32'(line_index) < 32'(MAX_A_LINES)) && (slot_cnt_reg < ORDER_C);
        unique case (cmd)
            CMD_TABLE: in_range = 32'(address) < 32'(MAX_A_LINES * ROW_WORDS);
            CMD_MASK:  in_range = 32'(address) < 32'(MAX_B_LINES);
            CMD_SLOT:  in_range = 1'b1;
            default:   in_range = 1'b0;
        endcase
        push = accept && in_range;
        push_entry.kind       = (cmd == CMD_TABLE) ? K_TABLE : (cmd == CMD_MASK) ? K_MASK : K_SLOT;
        push_entry.address    = address;
        push_entry.data       = {data_high, data_low};
        push_entry.line_index = line_index;
        push_entry.use_slot   = slot_use;
        push_entry.last       = last_index;
    end

    // Slot counter: slots past ORDER are ignored until the query ends.
    always_comb
    begin
        slot_cnt_next = slot_cnt_reg;
        if (accept && cmd == CMD_SLOT)
        begin
            if (last_index)
            begin
                slot_cnt_next = '0;
            end
            else if (slot_cnt_reg < ORDER_C)
            begin
                slot_cnt_next = slot_cnt_reg + SCW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_cnt_reg <= '0;
        end
        else
        begin
            slot_cnt_reg <= slot_cnt_next;
        end
    end

endmodule

// File: hdl/lbif_queue.sv
module lbif_queue
    import lbif_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head
);

    entry_t      slots_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slots_reg[rd_ptr_reg];

    // Payload storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: hdl/lbif_back.sv
`include "line_bitset_intersection_filter_top_defines.svh"

module lbif_back
    import lbif_pkg::*;
#(
    parameter int MAX_A_LINES = DEF_MAX_A_LINES,
    parameter int MAX_B_LINES = DEF_MAX_B_LINES,
    parameter int ORDER       = DEF_ORDER
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [12:0]  lines_in_use,
    input  logic         cover_mode,
    input  logic         head_valid,
    input  entry_t       head,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [5:0]   word_number,
    output logic [63:0]  survivor_word,
    output logic [12:0]  survivor_count,
    output logic [63:0]  union_low,
    output logic [35:0]  union_high,
    output logic         covers_all,
    output logic [1:0]   status,
    output logic         last_result
);

    localparam int TDEPTH = MAX_A_LINES * ROW_WORDS;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int MBW    = $clog2(MAX_B_LINES);

    typedef enum logic [3:0] {
        S_IDLE, S_ROW, S_ROW_END, S_FIN, S_MRD, S_MDAT, S_SCAN,
        S_SETTLE, S_ERD, S_EWAIT, S_ONE
    } state_t;

    state_t        state_reg, state_next;
    logic [6:0]    w_reg, w_next;
    logic [11:0]   li_reg, li_next;
    logic          last_reg, last_next;
    logic          started_reg, started_next;
    logic          emptied_reg, emptied_next;
    logic          nz_reg, nz_next;
    logic          rdv_reg, rdv_next;
    logic [5:0]    rdw_reg, rdw_next;
    logic [12:0]   cnt_reg, cnt_next;
    logic [63:0]   scan_reg, scan_next;
    logic          pend_reg, pend_next;
    logic [99:0]   union_reg, union_next;
    logic [1:0]    st_reg, st_next;
    logic          uen_reg, uen_next;

    logic          out_valid_reg, out_valid_next;
    logic [5:0]    o_wn_reg, o_wn_next;
    logic [63:0]   o_word_reg, o_word_next;
    logic [12:0]   o_cnt_reg, o_cnt_next;
    logic [99:0]   o_union_reg, o_union_next;
    logic          o_cov_reg, o_cov_next;
    logic [1:0]    o_st_reg, o_st_next;
    logic          o_last_reg, o_last_next;

    // Memory ports.
    logic              t_we;
    logic [TAW-1:0]    t_waddr, t_raddr;
    logic [63:0]       t_rdata;
    logic              m_we;
    logic [MBW-1:0]    m_waddr, m_raddr;
    logic [99:0]       m_rdata;
    logic              a_we;
    logic [5:0]        a_waddr, a_raddr;
    logic [63:0]       a_wdata, a_rdata;

    logic [19:0]   t_waddr_w, t_raddr_w;
    logic [11:0]   m_raddr_w;
    logic [12:0]   used_l;
    logic [6:0]    words;
    logic [12:0]   lim;
    logic [63:0]   lim_mask;
    logic [63:0]   row_word;
    logic          out_free;
    logic          load_out;
    logic          cov;
    logic [1:0]    cnt_st;

    lbif_ram #(.WIDTH(64), .DEPTH(TDEPTH)) u_table (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(head.data[63:0]),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    lbif_ram #(.WIDTH(POINTS), .DEPTH(MAX_B_LINES)) u_masks (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(head.data),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    lbif_ram #(.WIDTH(64), .DEPTH(ROW_WORDS)) u_accum (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    // Used lines, word count and last-word mask.
    always_comb
    begin
        used_l   = (32'(lines_in_use) > 32'(MAX_B_LINES)) ? 13'(MAX_B_LINES) : lines_in_use;
        words    = 7'((used_l + 13'd63) >> 6);
        lim      = used_l - {1'b0, w_reg[5:0], 6'd0};
        lim_mask = (lim < 13'd64) ? ~(64'hFFFF_FFFF_FFFF_FFFF << lim[5:0]) : '1;
        cov      = &union_reg;
        cnt_st   = (32'(cnt_reg) >= 32'(ORDER)) ? ST_ENOUGH : ST_FEW;
        out_free = !out_valid_reg || out_ready;
    end

    // Address formation.
    always_comb
    begin
        t_waddr_w = {2'b00, head.address};
        t_raddr_w = {2'b00, li_reg, w_reg[5:0]};
        m_raddr_w = {w_reg[5:0], low_index(scan_reg)};
        t_waddr   = t_waddr_w[TAW-1:0];
        t_raddr   = t_raddr_w[TAW-1:0];
        m_waddr   = head.address[MBW-1:0];
        m_raddr   = m_raddr_w[MBW-1:0];
        a_raddr   = w_reg[5:0];
        row_word  = started_reg ? (a_rdata & t_rdata) : t_rdata;
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        w_next       = w_reg;
        li_next      = li_reg;
        last_next    = last_reg;
        started_next = started_reg;
        emptied_next = emptied_reg;
        nz_next      = nz_reg;
        rdv_next     = 1'b0;
        rdw_next     = rdw_reg;
        cnt_next     = cnt_reg;
        scan_next    = scan_reg;
        pend_next    = 1'b0;
        union_next   = union_reg;
        st_next      = st_reg;
        uen_next     = uen_reg;
        pop          = 1'b0;
        t_we         = 1'b0;
        m_we         = 1'b0;
        a_we         = 1'b0;
        a_waddr      = rdw_reg;
        a_wdata      = row_word;
        load_out     = 1'b0;
        o_wn_next    = o_wn_reg;
        o_word_next  = o_word_reg;
        o_cnt_next   = o_cnt_reg;
        o_union_next = o_union_reg;
        o_cov_next   = o_cov_reg;
        o_st_next    = o_st_reg;
        o_last_next  = o_last_reg;

        // Row AND write-back, in the cycle after the read.
        if (rdv_reg)
        begin
            a_we = 1'b1;
            if ({1'b0, rdw_reg} < words && row_word != '0)
            begin
                nz_next = 1'b1;
            end
        end

        // Mask data of the previous survivor bit.
        if (pend_reg)
        begin
            union_next = union_reg | m_rdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    unique case (head.kind)
                        K_TABLE: t_we = 1'b1;
                        K_MASK:  m_we = 1'b1;
                        K_SLOT:
                        begin
                            li_next   = head.line_index;
                            last_next = head.last;
                            if (head.use_slot && !emptied_reg)
                            begin
                                w_next     = '0;
                                nz_next    = 1'b0;
                                state_next = S_ROW;
                            end
                            else if (head.last)
                            begin
                                state_next = S_FIN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ROW:
            begin
                rdv_next = 1'b1;
                rdw_next = w_reg[5:0];
                w_next   = w_reg + 7'd1;
                if (w_reg == 7'(ROW_WORDS - 1))
                begin
                    state_next = S_ROW_END;
                end
            end
            S_ROW_END:
            begin
                emptied_next = started_reg && !nz_next;
                started_next = 1'b1;
                state_next   = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (!started_reg || emptied_reg)
                begin
                    st_next    = started_reg ? ST_EMPTIED : ST_NOSLOT;
                    uen_next   = 1'b0;
                    state_next = S_ONE;
                end
                else
                begin
                    cnt_next   = '0;
                    union_next = '0;
                    w_next     = '0;
                    state_next = S_MRD;
                end
            end
            S_MRD:
            begin
                state_next = (w_reg == words) ? S_SETTLE : S_MDAT;
            end
            S_MDAT:
            begin
                a_we       = 1'b1;
                a_waddr    = w_reg[5:0];
                a_wdata    = a_rdata & lim_mask;
                cnt_next   = cnt_reg + 13'(pop_count(a_rdata & lim_mask));
                scan_next  = a_rdata & lim_mask;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_reg == '0)
                begin
                    w_next     = w_reg + 7'd1;
                    state_next = S_MRD;
                end
                else
                begin
                    pend_next = 1'b1;
                    scan_next = scan_reg & (scan_reg - 64'd1);
                end
            end
            S_SETTLE:
            begin
                w_next = '0;
                if (cover_mode)
                begin
                    st_next    = ST_ENOUGH;
                    uen_next   = 1'b1;
                    state_next = S_ONE;
                end
                else if (words == '0)
                begin
                    st_next    = cnt_st;
                    uen_next   = 1'b0;
                    state_next = S_ONE;
                end
                else
                begin
                    st_next    = cnt_st;
                    state_next = S_ERD;
                end
            end
            S_ERD:
            begin
                state_next = S_EWAIT;
            end
            S_EWAIT:
            begin
                if (out_free)
                begin
                    load_out     = 1'b1;
                    o_wn_next    = w_reg[5:0];
                    o_word_next  = a_rdata;
                    o_cnt_next   = cnt_reg;
                    o_union_next = union_reg;
                    o_cov_next   = cov;
                    o_st_next    = st_reg;
                    o_last_next  = (w_reg == words - 7'd1);
                    w_next       = w_reg + 7'd1;
                    if (w_reg == words - 7'd1)
                    begin
                        started_next = 1'b0;
                        emptied_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ERD;
                    end
                end
            end
            S_ONE:
            begin
                if (out_free)
                begin
                    load_out     = 1'b1;
                    o_wn_next    = '0;
                    o_word_next  = '0;
                    o_cnt_next   = '0;
                    o_union_next = uen_reg ? union_reg : '0;
                    o_cov_next   = uen_reg && cov;
                    o_st_next    = st_reg;
                    o_last_next  = 1'b1;
                    started_next = 1'b0;
                    emptied_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            emptied_reg   <= 1'b0;
            rdv_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            emptied_reg   <= emptied_next;
            rdv_reg       <= rdv_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        w_reg       <= w_next;
        li_reg      <= li_next;
        last_reg    <= last_next;
        nz_reg      <= nz_next;
        rdw_reg     <= rdw_next;
        cnt_reg     <= cnt_next;
        scan_reg    <= scan_next;
        union_reg   <= union_next;
        st_reg      <= st_next;
        uen_reg     <= uen_next;
        o_wn_reg    <= o_wn_next;
        o_word_reg  <= o_word_next;
        o_cnt_reg   <= o_cnt_next;
        o_union_reg <= o_union_next;
        o_cov_reg   <= o_cov_next;
        o_st_reg    <= o_st_next;
        o_last_reg  <= o_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign word_number    = o_wn_reg;
    assign survivor_word  = o_word_reg;
    assign survivor_count = o_cnt_reg;
    assign union_low      = o_union_reg[63:0];
    assign union_high     = o_union_reg[99:64];
    assign covers_all     = o_cov_reg;
    assign status         = o_st_reg;
    assign last_result    = o_last_reg;

    `LBIF_ASSERT_NOW(a_emptied_started, clk, rst_n, emptied_reg, started_reg)
    `LBIF_ASSERT_NOW(a_load_free, clk, rst_n, load_out, !out_valid_reg || out_ready)
    `LBIF_ASSERT_NEXT(a_row_end_started, clk, rst_n, state_reg == S_ROW_END, started_reg)

endmodule

// File: hdl/line_bitset_intersection_filter_top.sv
// A query slot reads and ANDs the row words of its line, one row word per cycle.
// The last slot adds a pass over the used words that counts and scans survivors,
// then the result words leave one by one; writes are taken only while idle.
// Throughput is set by the single read port of the table memory in the row loop.
// Reset (rst_n, asynchronous, active low) clears control state and config regs;
// datapath registers and memories are not cleared; memories need no clearing pass.
module line_bitset_intersection_filter_top
    import lbif_pkg::*;
#(
    parameter int MAX_A_LINES = DEF_MAX_A_LINES,
    parameter int MAX_B_LINES = DEF_MAX_B_LINES,
    parameter int ORDER       = DEF_ORDER
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // address, data_low, data_high, line_index, index_valid, zero pad
    input  logic [135:0]  s_tdata,
    // cmd
    input  logic [1:0]    s_tuser,
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    // word_number, survivor_word, survivor_count, union_low, union_high, covers_all
    output logic [183:0]  m_tdata,
    // status
    output logic [1:0]    m_tuser,
    output logic          m_tlast,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [12:0]   cfg_data
);

    logic [12:0] lines_in_use_reg;
    logic        cover_mode_reg;
    logic        push, q_full, pop, head_valid;
    entry_t      push_entry, head;
    logic [5:0]  word_number;
    logic [63:0] survivor_word, union_low;
    logic [12:0] survivor_count;
    logic [35:0] union_high;
    logic        covers_all;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_in_use_reg <= '0;
            cover_mode_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LINES: lines_in_use_reg <= cfg_data;
                REG_COVER: cover_mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    lbif_front #(
        .MAX_A_LINES(MAX_A_LINES), .MAX_B_LINES(MAX_B_LINES), .ORDER(ORDER)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .cmd(s_tuser),
        .address(s_tdata[17:0]),
        .data_low(s_tdata[81:18]),
        .data_high(s_tdata[117:82]),
        .line_index(s_tdata[129:118]),
        .index_valid(s_tdata[130]),
        .last_index(s_tlast),
        .push(push), .push_entry(push_entry), .q_full(q_full)
    );

    lbif_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_entry(push_entry), .full(q_full),
        .pop(pop), .head_valid(head_valid), .head(head)
    );

    lbif_back #(
        .MAX_A_LINES(MAX_A_LINES), .MAX_B_LINES(MAX_B_LINES), .ORDER(ORDER)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .lines_in_use(lines_in_use_reg), .cover_mode(cover_mode_reg),
        .head_valid(head_valid), .head(head), .pop(pop),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .word_number(word_number), .survivor_word(survivor_word),
        .survivor_count(survivor_count), .union_low(union_low),
        .union_high(union_high), .covers_all(covers_all),
        .status(m_tuser), .last_result(m_tlast)
    );

    assign m_tdata = {covers_all, union_high, union_low, survivor_count,
                      survivor_word, word_number};

endmodule
